>>> hdl/dtsd_pkg.sv
package dtsd_pkg;

    // Default sample width
    localparam int DEF_SAMPLE_BITS = 12;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVITY_SWING     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VALID_SWING        = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FALLBACK_PRECISION = 2'd3;

    // Register reset values
    localparam logic [7:0]  RST_WINDOW_LENGTH      = 8'd50;
    localparam logic [11:0] RST_ACTIVITY_SWING     = 12'd50;
    localparam logic [11:0] RST_VALID_SWING        = 12'd160;
    localparam logic [11:0] RST_FALLBACK_PRECISION = 12'd2;

    // Detector state reset values
    localparam int RST_THRESHOLD = 500;
    localparam int RST_PRECISION = 5;

    // Precision is swing / 32
    localparam int PRECISION_SHIFT = 5;

    // Saturation limit of the activity counter
    localparam logic [7:0] ACTIVITY_LIMIT = 8'd255;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  window_length;
        logic [11:0] activity_swing;
        logic [11:0] valid_swing;
        logic [11:0] fallback_precision;
    } t_cfg;

endpackage

>>> hdl/dynamic_threshold_step_detector_unit.sv
// A transferred sample is averaged into a two-entry queue that decouples the averaging
// front end from the window/threshold back end, which pops it into a result register
// that holds under stall. Throughput: one sample per cycle while the output does not stall.
// Reset (synchronous, active low) restores the register defaults and clears the
// sample history, queue and output valid; the min tracker restarts at half scale.
module dynamic_threshold_step_detector_unit #(
    parameter int SAMPLE_BITS = dtsd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [dtsd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [dtsd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_step_detected,
    output logic                                o_window_done,
    output logic [7:0]                          o_activity_count,
    output logic [11:0]                         o_threshold_level
);
    import dtsd_pkg::*;

    t_cfg                   r_cfg;
    logic                   in_accept;
    logic [SAMPLE_BITS-1:0] front_avg;
    logic [SAMPLE_BITS-1:0] q_avg;
    logic                   q_empty;
    logic                   q_full;
    logic                   q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length      <= RST_WINDOW_LENGTH;
            r_cfg.activity_swing     <= RST_ACTIVITY_SWING;
            r_cfg.valid_swing        <= RST_VALID_SWING;
            r_cfg.fallback_precision <= RST_FALLBACK_PRECISION;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH:      r_cfg.window_length      <= i_cfg_data[7:0];
                CFG_ACTIVITY_SWING:     r_cfg.activity_swing     <= i_cfg_data;
                CFG_VALID_SWING:        r_cfg.valid_swing        <= i_cfg_data;
                CFG_FALLBACK_PRECISION: r_cfg.fallback_precision <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input transfer whenever the queue has room
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    dtsd_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_sample (i_sample),
        .o_avg    (front_avg)
    );

    dtsd_queue #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_avg),
        .i_pop   (q_pop),
        .o_data  (q_avg),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dtsd_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_empty         (q_empty),
        .i_avg             (q_avg),
        .o_pop             (q_pop),
        .o_valid           (o_out_valid),
        .i_stall           (i_out_stall),
        .o_step_detected   (o_step_detected),
        .o_window_done     (o_window_done),
        .o_activity_count  (o_activity_count),
        .o_threshold_level (o_threshold_level)
    );

endmodule

>>> hdl/dtsd_front.sv
module dtsd_front #(
    parameter int SAMPLE_BITS = dtsd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_avg
);
    import dtsd_pkg::*;

    logic [SAMPLE_BITS-1:0] r_hist [3];
    logic [SAMPLE_BITS+1:0] sum;

    // 4-tap moving average of the new sample and the last three
    always_comb begin
        sum = {2'b00, i_sample} + {2'b00, r_hist[0]}
            + {2'b00, r_hist[1]} + {2'b00, r_hist[2]};
        o_avg = sum[SAMPLE_BITS+1:2];
    end

    // Sample history shifts on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist[0] <= '0;
            r_hist[1] <= '0;
            r_hist[2] <= '0;
        end else if (i_accept) begin
            r_hist[2] <= r_hist[1];
            r_hist[1] <= r_hist[0];
            r_hist[0] <= i_sample;
        end
    end

endmodule

>>> hdl/dtsd_queue.sv
module dtsd_queue #(
    parameter int WIDTH = dtsd_pkg::DEF_SAMPLE_BITS,
    parameter int DEPTH = dtsd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    import dtsd_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_BITS'(DEPTH));

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hdl/dtsd_back.sv
module dtsd_back #(
    parameter int SAMPLE_BITS = dtsd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dtsd_pkg::t_cfg         i_cfg,
    input  logic                   i_q_empty,
    input  logic [SAMPLE_BITS-1:0] i_avg,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_step_detected,
    output logic                   o_window_done,
    output logic [7:0]             o_activity_count,
    output logic [11:0]            o_threshold_level
);
    import dtsd_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int TW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
    localparam logic [SB:0] MIN_RESET   = (SB+1)'(1) << (SB - 1);
    localparam logic [SB:0] MIN_RESTART = (SB+1)'(1) << SB;

    // Detector state
    logic [SB-1:0] r_max;
    logic [SB:0]   r_min;
    logic [7:0]    r_count;
    logic [TW-1:0] r_thr;
    logic [TW-1:0] r_prec;
    logic          r_bad;
    logic [SB-1:0] r_slide;
    logic [7:0]    r_active;

    logic [SB-1:0] n_max;
    logic [SB:0]   n_min;
    logic [7:0]    n_count;
    logic [TW-1:0] n_thr;
    logic [TW-1:0] n_prec;
    logic          n_bad;
    logic [SB-1:0] n_slide;
    logic [7:0]    n_active;

    // Output register
    logic          r_out_valid;
    logic          r_step;
    logic          r_done;
    logic          n_step;
    logic          n_done;

    logic [SB-1:0] trk_max;
    logic [SB:0]   trk_min;
    logic [8:0]    cnt_inc;
    logic [SB:0]   swing_full;
    logic [SB-1:0] swing;
    logic [TW-1:0] swing_x;
    logic [SB-1:0] diff;

    // Pop when something is queued and the output register frees up
    assign o_pop = !i_q_empty && (!r_out_valid || !i_stall);

    // Window tracking, threshold update and sliding level
    always_comb begin
        trk_max = (i_avg > r_max) ? i_avg : r_max;
        trk_min = ({1'b0, i_avg} < r_min) ? {1'b0, i_avg} : r_min;
        cnt_inc = {1'b0, r_count} + 9'd1;

        // at window close max >= min, so the swing fits SB bits
        swing_full = {1'b0, trk_max} - trk_min;
        swing      = swing_full[SB-1:0];
        swing_x    = TW'(swing);

        n_max    = trk_max;
        n_min    = trk_min;
        n_count  = cnt_inc[7:0];
        n_thr    = r_thr;
        n_prec   = r_prec;
        n_bad    = r_bad;
        n_active = r_active;
        n_done   = 1'b0;

        if (cnt_inc >= {1'b0, i_cfg.window_length}) begin
            n_done  = 1'b1;
            n_count = '0;
            if (swing_x > TW'(i_cfg.activity_swing) && r_active < ACTIVITY_LIMIT) begin
                n_active = r_active + 8'd1;
            end
            n_thr = TW'(trk_min[SB-1:0]) + TW'(swing >> 1);
            n_max = '0;
            n_min = MIN_RESTART;
            if (swing_x >= TW'(i_cfg.valid_swing)) begin
                n_prec = TW'(swing >> PRECISION_SHIFT);
                n_bad  = 1'b0;
            end else begin
                n_prec = TW'(i_cfg.fallback_precision);
                n_bad  = 1'b1;
            end
        end

        // sliding level jumps only by at least the precision
        diff    = (i_avg >= r_slide) ? (i_avg - r_slide) : (r_slide - i_avg);
        n_slide = (TW'(diff) >= n_prec) ? i_avg : r_slide;

        // downward crossing of the new threshold in a good window
        n_step = (TW'(r_slide) >= n_thr) && (TW'(n_slide) < n_thr) && !n_bad;
    end

    // State update on each popped item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= '0;
            r_min    <= MIN_RESET;
            r_count  <= '0;
            r_thr    <= TW'(RST_THRESHOLD);
            r_prec   <= TW'(RST_PRECISION);
            r_bad    <= 1'b0;
            r_slide  <= '0;
            r_active <= '0;
        end else if (o_pop) begin
            r_max    <= n_max;
            r_min    <= n_min;
            r_count  <= n_count;
            r_thr    <= n_thr;
            r_prec   <= n_prec;
            r_bad    <= n_bad;
            r_slide  <= n_slide;
            r_active <= n_active;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_step <= n_step;
            r_done <= n_done;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_step_detected   = r_step;
    assign o_window_done     = r_done;
    assign o_activity_count  = r_active;
    assign o_threshold_level = r_thr[11:0];

endmodule
